FILE: rtl/core/osf_pkg.sv
// Package for the overlapping sample framer: field widths, register codes,
// scaling constants and the helpers that clamp frame length and overlap.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package osf_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int LEN_W      = 7;
  localparam int OVL_W      = 6;
  localparam int POS_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int FRAC_BITS  = 12;
  localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;
  localparam int SCALED_W   = PROD_W - FRAC_BITS;

  localparam logic [LEN_W-1:0]    FRAME_LEN_RST = 7'd64;
  localparam logic [OVL_W-1:0]    OVERLAP_RST   = 6'd0;
  localparam logic [GAIN_W-1:0]   GAIN_RST      = 16'd4096;
  localparam logic [LEN_W-1:0]    MIN_FRAME_LEN = 7'd2;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = 33'sd2048;
  localparam logic signed [SCALED_W-1:0] SAT_MAX  = 21'sd32767;
  localparam logic signed [SCALED_W-1:0] SAT_MIN  = -21'sd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_LEN = 2'd0,
    REG_OVERLAP   = 2'd1,
    REG_GAIN      = 2'd2
  } reg_idx_t;

  // Frame length as used: at least two, at most the ring depth.
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw,
                                               input logic [LEN_W-1:0] max_len);
    logic [LEN_W-1:0] fl;
    fl = raw;
    if (fl < MIN_FRAME_LEN) fl = MIN_FRAME_LEN;
    if (fl > max_len) fl = max_len;
    return fl;
  endfunction

  // Overlap as used: never reaches the frame length.
  function automatic logic [LEN_W-1:0] eff_ovl(input logic [OVL_W-1:0] raw,
                                               input logic [LEN_W-1:0] fl);
    logic [LEN_W-1:0] ov;
    ov = {1'b0, raw};
    if (ov >= fl) ov = fl - 7'd1;
    return ov;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/osf_if.sv
// Channel interfaces of the overlapping sample framer: sample input,
// framed result output and configuration write port. Uses osf_pkg widths.
`default_nettype none

interface osf_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [osf_pkg::SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface osf_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [osf_pkg::SAMPLE_W-1:0] value;
  logic        [osf_pkg::POS_W-1:0]    position;
  logic                                last;
  modport source (output valid, output value, output position, output last, input ready);
  modport sink   (input valid, input value, input position, input last, output ready);
endinterface

interface osf_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [osf_pkg::CFG_IDX_W-1:0]      index;
  logic [osf_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/osf_scale.sv
// Gain unit of the framer: one registered 16x17 multiply, then round half up
// and saturate to 16 bits. Depends on osf_pkg.
`default_nettype none

module osf_scale (
  input  wire logic                                clk,
  input  wire logic                                load,
  input  wire logic signed [osf_pkg::SAMPLE_W-1:0] sample,
  input  wire logic        [osf_pkg::GAIN_W-1:0]   gain,
  output logic signed      [osf_pkg::SAMPLE_W-1:0] scaled
);

  logic signed [osf_pkg::PROD_W-1:0]   prod_r;
  logic signed [osf_pkg::PROD_W-1:0]   rounded;
  logic signed [osf_pkg::SCALED_W-1:0] shifted;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= osf_pkg::PROD_W'(sample) * $signed({1'b0, gain});
    end
  end

  // The arithmetic shift floors, so adding half first rounds half up.
  always_comb begin
    rounded = prod_r + osf_pkg::ROUND_HALF;
    shifted = osf_pkg::SCALED_W'(rounded >>> osf_pkg::FRAC_BITS);
    if (shifted > osf_pkg::SAT_MAX) begin
      scaled = osf_pkg::SAMPLE_W'(osf_pkg::SAT_MAX);
    end else if (shifted < osf_pkg::SAT_MIN) begin
      scaled = osf_pkg::SAMPLE_W'(osf_pkg::SAT_MIN);
    end else begin
      scaled = osf_pkg::SAMPLE_W'(shifted);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/overlapping_sample_framer.sv
// Top level of the overlapping sample framer: sequencer, ring memory and
// configuration registers. Depends on osf_pkg, osf_if.sv and osf_scale.
//
// Usage. Signed 16-bit samples arrive on in_ch. Each one is scaled by the
// gain register (unsigned Q4.12, 4096 is unity), rounded half up, saturated
// to 16 bits and stored in a ring of frame_len entries. The first frame is
// counted as if overlap zero samples came first. When a frame is full, the
// whole ring goes out on out_ch oldest first, one item per entry, with its
// position in the frame and last set on the final item. The newest overlap
// entries are kept, so each later frame needs frame_len - overlap samples.
// The cfg_ch port writes frame_len (index 0), overlap (index 1) and gain
// (index 2); writing frame_len or overlap restarts framing but keeps the
// ring contents. Configuration is always ready and must be written idle.
// Steps. A sample that completes no frame passes the multiply, then the
// round and write step, before in_ch is ready again. A sample that completes
// a frame adds a memory read and then a present step per result item, and
// the input stays closed until the whole frame is taken. The single-port
// ring read, one entry per result item, paces the frame out.
// When the receiver stalls, the current result item holds on out_ch and no
// sample is taken. Reset clears the registers to frame_len 64, overlap 0,
// gain 4096, and marks every ring entry as zero through its valid bit.
`default_nettype none

module overlapping_sample_framer #(
  parameter int MAX_FRAME_LEN = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  osf_in_if.sink     in_ch,
  osf_out_if.source  out_ch,
  osf_cfg_if.sink    cfg_ch
);

  localparam int AW = (MAX_FRAME_LEN > 1) ? $clog2(MAX_FRAME_LEN) : 1;
  localparam logic [osf_pkg::LEN_W-1:0] MAX_LEN = osf_pkg::LEN_W'(MAX_FRAME_LEN);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_SHOW
  } state_t;

  state_t state_r;

  logic [osf_pkg::LEN_W-1:0]  frame_len_r;
  logic [osf_pkg::OVL_W-1:0]  overlap_r;
  logic [osf_pkg::GAIN_W-1:0] gain_r;

  logic [AW-1:0]              wp_r;
  logic [AW-1:0]              fsp_r;
  logic [osf_pkg::LEN_W-1:0]  fill_r;
  logic [AW-1:0]              idx_r;
  logic [osf_pkg::POS_W-1:0]  pos_r;
  logic                       last_r;
  logic [MAX_FRAME_LEN-1:0]   vld_r;

  logic signed [osf_pkg::SAMPLE_W-1:0] ring_mem [MAX_FRAME_LEN];
  logic signed [osf_pkg::SAMPLE_W-1:0] rd_data_r;
  logic signed [osf_pkg::SAMPLE_W-1:0] scaled;

  logic                      in_fire;
  logic                      out_fire;
  logic                      cfg_fire;
  logic [osf_pkg::LEN_W-1:0] fl;
  logic [osf_pkg::LEN_W-1:0] ov;
  logic [osf_pkg::LEN_W-1:0] wp_inc;
  logic [AW-1:0]             wp_nxt;
  logic [osf_pkg::LEN_W-1:0] fill_nxt;
  logic [osf_pkg::LEN_W-1:0] pop;
  logic [osf_pkg::LEN_W-1:0] start_w;
  logic [osf_pkg::LEN_W-1:0] np_w;
  logic [osf_pkg::LEN_W-1:0] idx_inc;
  logic [AW-1:0]             idx_nxt;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign cfg_ch.ready    = 1'b1;
  assign out_ch.valid    = (state_r == ST_SHOW);
  assign out_ch.value    = rd_data_r;
  assign out_ch.position = pos_r;
  assign out_ch.last     = last_r;

  assign fl = osf_pkg::eff_len(frame_len_r, MAX_LEN);
  assign ov = osf_pkg::eff_ovl(overlap_r, fl);

  // Pointers stay below the frame length, since a change of length restarts
  // them, so wrapping is a compare against the length and no modulo.
  always_comb begin
    wp_inc   = osf_pkg::LEN_W'(wp_r) + 7'd1;
    wp_nxt   = (wp_inc > fl - 7'd1) ? '0 : AW'(wp_inc);
    fill_nxt = fill_r + 7'd1;
    pop      = osf_pkg::LEN_W'(fsp_r);
    start_w  = (pop >= ov) ? pop - ov : pop + fl - ov;
    np_w     = pop + fl - ov;
    if (np_w > fl - 7'd1) np_w = np_w - fl;
    idx_inc  = osf_pkg::LEN_W'(idx_r) + 7'd1;
    idx_nxt  = (idx_inc == fl) ? '0 : AW'(idx_inc);
  end

  osf_scale u_scale (
    .clk    (clk),
    .load   (in_fire),
    .sample (in_ch.sample),
    .gain   (gain_r),
    .scaled (scaled)
  );

  // Ring memory: one write in the write step, one registered read per result.
  always_ff @(posedge clk) begin
    if (state_r == ST_WRITE) begin
      ring_mem[wp_nxt] <= scaled;
    end
    if (state_r == ST_READ) begin
      rd_data_r <= vld_r[idx_r] ? ring_mem[idx_r] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      frame_len_r <= osf_pkg::FRAME_LEN_RST;
      overlap_r   <= osf_pkg::OVERLAP_RST;
      gain_r      <= osf_pkg::GAIN_RST;
      wp_r        <= '0;
      fsp_r       <= AW'(1);
      fill_r      <= osf_pkg::eff_ovl(osf_pkg::OVERLAP_RST,
                       osf_pkg::eff_len(osf_pkg::FRAME_LEN_RST, MAX_LEN));
      idx_r       <= '0;
      pos_r       <= '0;
      last_r      <= 1'b0;
      vld_r       <= '0;
    end else begin
      if (cfg_fire) begin
        unique case (osf_pkg::reg_idx_t'(cfg_ch.index))
          osf_pkg::REG_FRAME_LEN: begin
            frame_len_r <= cfg_ch.data[osf_pkg::LEN_W-1:0];
            wp_r        <= '0;
            fsp_r       <= AW'(1);
            fill_r      <= osf_pkg::eff_ovl(overlap_r,
                             osf_pkg::eff_len(cfg_ch.data[osf_pkg::LEN_W-1:0], MAX_LEN));
          end
          osf_pkg::REG_OVERLAP: begin
            overlap_r <= cfg_ch.data[osf_pkg::OVL_W-1:0];
            wp_r      <= '0;
            fsp_r     <= AW'(1);
            fill_r    <= osf_pkg::eff_ovl(cfg_ch.data[osf_pkg::OVL_W-1:0], fl);
          end
          osf_pkg::REG_GAIN: begin
            gain_r <= cfg_ch.data[osf_pkg::GAIN_W-1:0];
          end
          default: begin
          end
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            state_r <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          // The product is registered; round, store and count the sample.
          wp_r          <= wp_nxt;
          vld_r[wp_nxt] <= 1'b1;
          fill_r        <= fill_nxt;
          if (fill_nxt >= fl) begin
            idx_r   <= AW'(start_w);
            pos_r   <= '0;
            state_r <= ST_READ;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_READ: begin
          last_r  <= (osf_pkg::LEN_W'(pos_r) == fl - 7'd1);
          state_r <= ST_SHOW;
        end
        ST_SHOW: begin
          if (out_fire) begin
            if (last_r) begin
              // Keep the newest overlap entries for the next frame.
              fill_r  <= ov;
              fsp_r   <= AW'(np_w);
              state_r <= ST_IDLE;
            end else begin
              idx_r   <= idx_nxt;
              pos_r   <= pos_r + 6'd1;
              state_r <= ST_READ;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/osf_checker.sv
// Port-level assertions for the overlapping sample framer, attached to the
// top level by the bind statement below. Depends on osf_pkg and the top level.
`default_nettype none

module osf_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic signed [osf_pkg::SAMPLE_W-1:0] out_value,
  input wire logic        [osf_pkg::POS_W-1:0]    out_position,
  input wire logic                                out_last
);

  // A stalled result item holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value)
      && $stable(out_position) && $stable(out_last))
    else $error("result item changed while stalled");

  // Samples are never taken while a frame is being delivered.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result item is shown");

  // Each sample taken keeps the block busy, so in_ready drops once it is taken.
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after taking a sample");

  // Within a frame, the input stays closed until the last item is taken.
  a_frame_closed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> !in_ready)
    else $error("input ready in the middle of a frame");

endmodule

bind overlapping_sample_framer osf_checker u_osf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_value    (out_ch.value),
  .out_position (out_ch.position),
  .out_last     (out_ch.last)
);

`default_nettype wire
